// ===== rtl/svld_pkg.sv =====
// Shared types and constants for the sync/varint-length deframer.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package svld_pkg;

  localparam logic [7:0] SYNC_RESET      = 8'hAA;
  localparam int         MAX_LEN_BYTES_D = 2;
  localparam int         BYTE_W          = 8;
  localparam int         CNT_W           = 32;

  // The fourth code is unused and behaves as hunting.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_e;

  // Request held in the input register.
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } s1_t;

endpackage

`default_nettype wire

// ===== rtl/svld_if.sv =====
// Valid/ready channel interfaces for the deframer: received bytes in, results out.
// Depends on svld_pkg for field widths.
`default_nettype none

interface svld_byte_if
  import svld_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface svld_res_if
  import svld_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              first_of_packet;
  logic              last_of_packet;
  logic              empty_packet;
  logic [CNT_W-1:0]  packets_seen;
  logic [CNT_W-1:0]  bytes_dropped;

  modport source (output valid, output payload_byte, output first_of_packet,
                  output last_of_packet, output empty_packet, output packets_seen,
                  output bytes_dropped, input ready);
  modport sink   (input valid, input payload_byte, input first_of_packet,
                  input last_of_packet, input empty_packet, input packets_seen,
                  input bytes_dropped, output ready);
endinterface

`default_nettype wire

// ===== rtl/svld_in_stage.sv =====
// Input register of the deframer: captures one received byte per request.
// Depends on svld_pkg and svld_if.
`default_nettype none

module svld_in_stage
  import svld_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  svld_byte_if.sink  rx_i,
  input  wire logic  adv_i,
  output s1_t        s1_o
);

  logic              vld_q, vld_d;
  logic [BYTE_W-1:0] data_q;
  logic              take;

  // Accept when empty or when the held byte moves on this cycle.
  assign rx_i.ready = !vld_q || adv_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= rx_i.in_byte;
    end
  end

  assign s1_o.vld  = vld_q;
  assign s1_o.data = data_q;

endmodule

`default_nettype wire

// ===== rtl/svld_deframe.sv =====
// Deframing state update and result register: sync hunt, LEB128 length, payload pass.
// Depends on svld_pkg and svld_if.
`default_nettype none

module svld_deframe
  import svld_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_D
)(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [BYTE_W-1:0] cfg_wdata_i,
  input  s1_t                    s1_i,
  output logic                   adv_o,
  svld_res_if.source             res_o
);

  localparam int LenW = 7 * MAX_LENGTH_BYTES;
  localparam int TkW  = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES) : 1;
  localparam logic [TkW-1:0] TkLast = TkW'(MAX_LENGTH_BYTES - 1);

  logic [BYTE_W-1:0] sync_q;
  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [TkW-1:0]    taken_q, taken_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic              first_q, first_d;
  logic [CNT_W-1:0]  pkt_q, pkt_d;
  logic [CNT_W-1:0]  drop_q, drop_d;

  logic              out_vld_q, out_vld_d;
  logic              emit;
  logic [BYTE_W-1:0] e_byte;
  logic              e_first, e_last, e_empty;

  logic [LenW-1:0]   len_new;
  logic [LenW-1:0]   rem_dec;
  logic              fire;
  logic [BYTE_W-1:0] b;

  // Advance the input register when the result slot is free or being taken.
  assign adv_o = !out_vld_q || res_o.ready;
  assign fire  = s1_i.vld && adv_o;
  assign b     = s1_i.data;

  assign len_new = len_q | (LenW'(b[6:0]) << (taken_q * 7));
  assign rem_dec = (rem_q != '0) ? rem_q - LenW'(1) : rem_q;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    taken_d = taken_q;
    rem_d   = rem_q;
    first_d = first_q;
    pkt_d   = pkt_q;
    drop_d  = drop_q;
    emit    = 1'b0;
    e_byte  = '0;
    e_first = 1'b0;
    e_last  = 1'b0;
    e_empty = 1'b0;
    if (fire) begin
      case (phase_q)
        PH_LEN: begin
          if (!b[7]) begin
            if (len_new == '0) begin
              pkt_d   = pkt_q + CNT_W'(1);
              phase_d = PH_HUNT;
              emit    = 1'b1;
              e_last  = 1'b1;
              e_empty = 1'b1;
            end else begin
              rem_d   = len_new;
              first_d = 1'b1;
              phase_d = PH_PAY;
            end
          end else if (taken_q == TkLast) begin
            // Length field too long: count one drop, hunt again.
            drop_d  = drop_q + CNT_W'(1);
            phase_d = PH_HUNT;
          end else begin
            len_d   = len_new;
            taken_d = taken_q + TkW'(1);
          end
        end
        PH_PAY: begin
          first_d = 1'b0;
          rem_d   = rem_dec;
          emit    = 1'b1;
          e_byte  = b;
          e_first = first_q;
          e_last  = (rem_dec == '0);
          if (rem_dec == '0) begin
            pkt_d   = pkt_q + CNT_W'(1);
            phase_d = PH_HUNT;
          end
        end
        default: begin
          if (b == sync_q) begin
            len_d   = '0;
            taken_d = '0;
            phase_d = PH_LEN;
          end else begin
            drop_d  = drop_q + CNT_W'(1);
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = emit;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q    <= SYNC_RESET;
      phase_q   <= PH_HUNT;
      len_q     <= '0;
      taken_q   <= '0;
      rem_q     <= '0;
      first_q   <= 1'b0;
      pkt_q     <= '0;
      drop_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
      phase_q   <= phase_d;
      len_q     <= len_d;
      taken_q   <= taken_d;
      rem_q     <= rem_d;
      first_q   <= first_d;
      pkt_q     <= pkt_d;
      drop_q    <= drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_o.payload_byte    <= e_byte;
      res_o.first_of_packet <= e_first;
      res_o.last_of_packet  <= e_last;
      res_o.empty_packet    <= e_empty;
      res_o.packets_seen    <= pkt_d;
      res_o.bytes_dropped   <= drop_d;
    end
  end

  assign res_o.valid = out_vld_q;

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_o.empty_packet |->
      res_o.last_of_packet && !res_o.first_of_packet && res_o.payload_byte == '0)
    else $error("empty packet result malformed");

  a_pay_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> rem_q != '0)
    else $error("payload phase with no bytes remaining");

  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> res_o.packets_seen == pkt_q && res_o.bytes_dropped == drop_q)
    else $error("held result counters disagree with state");

  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_i.vld && !adv_o |=> s1_i.vld && $stable(s1_i.data))
    else $error("stalled input register lost its byte");

endmodule

`default_nettype wire

// ===== rtl/sync_varint_length_deframer.sv =====
// Channel   Dir  Payload                                          Handshake
// rx_i      in   in_byte[7:0]                                     valid/ready
// res_o     out  payload_byte, first/last/empty, packets_seen,    valid/ready
//                bytes_dropped
// cfg       in   cfg_wdata_i[7:0] (sync value)                    cfg_we_i, no wait
//
// One byte is accepted per cycle while res_o is not stalled. A byte passes the input
// register and then the result register before its result, if any, is valid on res_o;
// the state update between the two is combinational. A stalled result holds; the input
// register accepts a byte while it is empty or while the result slot is free or being taken.
// Reset returns to hunting with sync value 0xAA and both counters at zero.
//
// Top level of the deframer. Depends on svld_pkg, svld_if, svld_in_stage, svld_deframe.
`default_nettype none

module sync_varint_length_deframer
  import svld_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MAX_LEN_BYTES_D
)(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [BYTE_W-1:0] cfg_wdata_i,
  svld_byte_if.sink              rx_i,
  svld_res_if.source             res_o
);

  s1_t  s1;
  logic adv;

  svld_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .adv_i  (adv),
    .s1_o   (s1)
  );

  svld_deframe #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_deframe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s1_i        (s1),
    .adv_o       (adv),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_sync_varint_length_deframer.sv =====
`timescale 1ns / 100ps
// Testbench for sync_varint_length_deframer. It drives framed byte streams with random gaps
// and result stalls, and checks each result against a predictor that runs in step with it.
// Depends on svld_pkg, svld_if and the deframer RTL.

import svld_pkg::*;

typedef struct {
  logic [BYTE_W-1:0] payload_byte;
  logic              first_of_packet;
  logic              last_of_packet;
  logic              empty_packet;
  logic [CNT_W-1:0]  packets_seen;
  logic [CNT_W-1:0]  bytes_dropped;
} deframe_out_t;

class deframe_board;
  logic [BYTE_W-1:0] sync_val;
  phase_e            phase;
  logic [13:0]       len_acc;
  int unsigned       len_taken;
  logic [13:0]       remaining;
  bit                at_first;
  logic [CNT_W-1:0]  pkt_cnt;
  logic [CNT_W-1:0]  drop_cnt;
  deframe_out_t      want_q[$];
  int                errors;

  function new();
    sync_val  = SYNC_RESET;
    phase     = PH_HUNT;
    len_acc   = '0;
    len_taken = 0;
    remaining = '0;
    at_first  = 1'b0;
    pkt_cnt   = '0;
    drop_cnt  = '0;
    errors    = 0;
  endfunction

  function void set_sync(logic [BYTE_W-1:0] v);
    sync_val = v;
  endfunction

  function void push_frag(logic [BYTE_W-1:0] b, bit first_f, bit last_f, bit empty_f);
    deframe_out_t frag;
    frag.payload_byte    = b;
    frag.first_of_packet = first_f;
    frag.last_of_packet  = last_f;
    frag.empty_packet    = empty_f;
    frag.packets_seen    = pkt_cnt;
    frag.bytes_dropped   = drop_cnt;
    want_q.insert(want_q.size(), frag);
  endfunction

  // Advance the deframer state by one accepted byte.
  function void take_byte(logic [BYTE_W-1:0] b);
    int unsigned shift;
    bit          first_f;
    case (phase)
      PH_LEN: begin
        shift = 7 * (len_taken % MAX_LEN_BYTES_D);
        len_acc = len_acc | (14'(b[6:0]) << shift);
        len_taken++;
        if (!b[7]) begin
          if (len_acc == '0) begin
            pkt_cnt++;
            phase = PH_HUNT;
            push_frag('0, 1'b0, 1'b1, 1'b1);
          end else begin
            remaining = len_acc;
            at_first  = 1'b1;
            phase     = PH_PAY;
          end
        end else if (len_taken >= MAX_LEN_BYTES_D) begin
          // length field too long: drop it and hunt again
          drop_cnt++;
          phase = PH_HUNT;
        end
      end
      PH_PAY: begin
        first_f  = at_first;
        at_first = 1'b0;
        if (remaining != '0) remaining--;
        if (remaining == '0) begin
          pkt_cnt++;
          phase = PH_HUNT;
        end
        push_frag(b, first_f, remaining == '0, 1'b0);
      end
      default: begin
        if (b == sync_val) begin
          len_acc   = '0;
          len_taken = 0;
          phase     = PH_LEN;
        end else begin
          drop_cnt++;
          phase = PH_HUNT;
        end
      end
    endcase
  endfunction

  task report(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    errors++;
  endtask

  task check_result(deframe_out_t got);
    deframe_out_t want;
    if (want_q.size() == 0) begin
      report($sformatf("result with nothing pending, payload_byte=%02h", got.payload_byte));
      return;
    end
    want = want_q.pop_front();
    if (got.payload_byte !== want.payload_byte)
      report($sformatf("payload_byte got %02h want %02h", got.payload_byte, want.payload_byte));
    if (got.first_of_packet !== want.first_of_packet)
      report($sformatf("first_of_packet got %b want %b", got.first_of_packet,
                       want.first_of_packet));
    if (got.last_of_packet !== want.last_of_packet)
      report($sformatf("last_of_packet got %b want %b", got.last_of_packet,
                       want.last_of_packet));
    if (got.empty_packet !== want.empty_packet)
      report($sformatf("empty_packet got %b want %b", got.empty_packet, want.empty_packet));
    if (got.packets_seen !== want.packets_seen)
      report($sformatf("packets_seen got %0d want %0d", got.packets_seen, want.packets_seen));
    if (got.bytes_dropped !== want.bytes_dropped)
      report($sformatf("bytes_dropped got %0d want %0d", got.bytes_dropped,
                       want.bytes_dropped));
  endtask
endclass

module tb_sync_varint_length_deframer;
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [BYTE_W-1:0] cfg_wdata_i;

  svld_byte_if rx_if ();
  svld_res_if  res_if ();

  deframe_board board;
  int           sent_cnt;
  bit           calm;
  int           hold_token;

  sync_varint_length_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("Timeout: deframer stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request, none when calm.
  initial begin : res_ready_drive
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = 79;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 7);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : res_monitor
    deframe_out_t got;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.payload_byte    = res_if.payload_byte;
      got.first_of_packet = res_if.first_of_packet;
      got.last_of_packet  = res_if.last_of_packet;
      got.empty_packet    = res_if.empty_packet;
      got.packets_seen    = res_if.packets_seen;
      got.bytes_dropped   = res_if.bytes_dropped;
      board.check_result(got);
    end
  end

  // Offer one byte; hold it until the request is taken, then maybe idle a few cycles.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    rx_if.valid   <= 1'b1;
    rx_if.in_byte <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    board.take_byte(b);
    sent_cnt++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 6) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(input logic [13:0] len, input bit redundant, input bit bad_len);
    logic [BYTE_W-1:0] sync = board.sync_val;
    logic [BYTE_W-1:0] noise;
    repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 2)) begin
      noise = 8'($urandom);
      if (noise == sync) noise = noise ^ 8'h01;
      send_byte(noise);
    end
    send_byte(sync);
    if (bad_len) begin
      send_byte(8'h80 | 8'($urandom));
      send_byte(8'h80 | 8'($urandom));
      return;
    end
    if (len < 128 && !redundant) begin
      send_byte({1'b0, len[6:0]});
    end else begin
      send_byte({1'b1, len[6:0]});
      send_byte({1'b0, len[13:7]});
    end
    for (int i = 0; i < len; i++)
      send_byte(($urandom_range(0, 9) == 0) ? sync : 8'($urandom));
  endtask

  task automatic random_traffic(input int quota);
    int stop_at = sent_cnt + quota;
    int pick;
    int len;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 14) begin
        send_frame('0, 1'b0, 1'b1);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      len = 0;
        else if (pick < 75) len = $urandom_range(1, 8);
        else if (pick < 92) len = $urandom_range(9, 40);
        else if (pick < 96) len = $urandom_range(41, 127);
        else                len = $urandom_range(128, 300);
        send_frame(14'(len), len < 128 && $urandom_range(0, 7) == 0, 1'b0);
      end
    end
  endtask

  // Drop valid and wait for every pending result plus the pipeline depth.
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (board.want_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_sync(input logic [BYTE_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_sync(v);
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] directed_q[$];
    logic [BYTE_W-1:0] sync_plan[5];
    board         = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rx_if.valid   = 1'b0;
    rx_if.in_byte = '0;
    sent_cnt      = 0;
    calm          = 1'b0;
    hold_token    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // noise, empty packet, redundant zero length, one-byte packet, sync inside payload,
    // overlong length, redundant two-byte length of one
    directed_q = '{8'h00, 8'hFF,
                   8'hAA, 8'h00,
                   8'hAA, 8'h80, 8'h00,
                   8'hAA, 8'h01, 8'hFF,
                   8'hAA, 8'h03, 8'hAA, 8'h00, 8'h7F,
                   8'hAA, 8'hFF, 8'hFF,
                   8'hAA, 8'h81, 8'h00, 8'h80};
    foreach (directed_q[i]) send_byte(directed_q[i]);

    sync_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), SYNC_RESET};
    foreach (sync_plan[p]) begin
      settle();
      write_sync(sync_plan[p]);
      if (p == 1) begin
        // hold the result side off while a long packet keeps arriving
        hold_token++;
        send_frame(14'd60, 1'b0, 1'b0);
      end
      if (p == 4) begin
        calm = 1'b1;
        send_frame(14'd200, 1'b0, 1'b0);
      end
      random_traffic(90);
    end

    rx_if.valid <= 1'b0;
    for (int i = 0; i < 20000 && board.want_q.size() != 0; i++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (board.want_q.size() != 0)
      board.report($sformatf("%0d expected results never arrived", board.want_q.size()));
    if (board.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== sync_varint_length_deframer.f =====
rtl/svld_pkg.sv
rtl/svld_if.sv
rtl/svld_in_stage.sv
rtl/svld_deframe.sv
rtl/sync_varint_length_deframer.sv
verif/tb_sync_varint_length_deframer.sv
